/* hw/rtl/periodic_event_timer_table_unit_macros.svh */
// Assertion macros for the periodic event timer table.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PERIODIC_EVENT_TIMER_TABLE_UNIT_MACROS_SVH
`define PERIODIC_EVENT_TIMER_TABLE_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define PET_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pet assertion failed");

// next-cycle implication, masked during reset
`define PET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pet assertion failed");

`endif

/* hw/rtl/pet_pkg.sv */
// Shared types and codes for the periodic event timer table.
// No dependencies.
`default_nettype none

package pet_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_PROCESS = 3'd1,
    OP_ADD     = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_PAUSE   = 3'd5,
    OP_RESUME  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_MOVE_RD,
    S_MOVE,
    S_DONE
  } state_e;

  localparam int TAG_W  = 8;
  localparam int PER_W  = 16;
  localparam int SLOT_W = 5;

  typedef struct packed {
    logic [2:0]       func;
    logic [TAG_W-1:0] event_tag;
    logic [PER_W-1:0] period;
    logic             count_enable;
  } cmd_t;

  typedef struct packed {
    logic              fired;
    logic [TAG_W-1:0]  fired_tag;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] counter;
    logic             active;
  } entry_t;

  // verdict of the slot unit on one entry
  typedef struct packed {
    logic   fire;
    logic   match;
    logic   hit;
    entry_t upd;
  } unit_res_t;

endpackage

`default_nettype wire

/* hw/rtl/pet_entry_ram.sv */
// Entry store: one write port, one registered read port.
// Depends on pet_pkg for the entry type.
`default_nettype none

module pet_entry_ram #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   wa,
  input  wire pet_pkg::entry_t    wd,
  input  wire logic [IDX_W-1:0]   ra,
  output pet_pkg::entry_t         rd
);

  pet_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

/* hw/rtl/pet_slot_unit.sv */
// Shared per-slot unit: due compare, tag match and entry update.
// Depends on pet_pkg for op codes and the entry type.
`default_nettype none

module pet_slot_unit (
  input  wire logic [2:0]                 op,
  input  wire logic [pet_pkg::TAG_W-1:0]  tag,
  input  wire pet_pkg::entry_t            entry,
  output pet_pkg::unit_res_t              res
);

  logic fire;
  logic match;
  logic not_sat;

  assign fire    = entry.counter >= entry.period;
  assign match   = entry.tag == tag;
  assign not_sat = entry.counter != '1;

  always_comb begin
    res       = '0;
    res.fire  = fire;
    res.match = match;
    res.upd   = entry;
    case (op)
      pet_pkg::OP_TICK: begin
        res.hit         = entry.active && not_sat;
        res.upd.counter = entry.counter + 1'b1;
      end
      pet_pkg::OP_PROCESS: begin
        res.hit         = fire;
        res.upd.counter = '0;
      end
      pet_pkg::OP_PAUSE: begin
        res.hit        = match;
        res.upd.active = 1'b0;
      end
      pet_pkg::OP_RESUME: begin
        res.hit        = match;
        res.upd.active = 1'b1;
      end
      pet_pkg::OP_REMOVE: begin
        res.hit = match;
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/pet_ctrl.sv */
// Sequencer: walks the slots through the shared unit and drives the result register.
// Depends on pet_pkg and the assertion macros header.
`default_nettype none
`include "periodic_event_timer_table_unit_macros.svh"

module pet_ctrl #(
  parameter int MAX_EVENTS = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire pet_pkg::cmd_t              cmd,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output pet_pkg::rsp_t                   rsp,
  output logic [2:0]                      op,
  output logic [pet_pkg::TAG_W-1:0]       tag,
  output logic [IDX_W-1:0]                idx,
  output logic                            we,
  output logic [IDX_W-1:0]                wa,
  output pet_pkg::entry_t                 wd,
  input  wire pet_pkg::entry_t            rd,
  input  wire pet_pkg::unit_res_t         ures
);

  pet_pkg::state_e state, state_next;

  logic [pet_pkg::PER_W-1:0] per, per_next;
  logic                      en, en_next;
  logic [2:0]                op_next;
  logic [pet_pkg::TAG_W-1:0] tag_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [IDX_W-1:0]          idx_next;
  logic [IDX_W-1:0]          res_slot, res_slot_next;
  logic                      found, found_next;
  logic [1:0]                st, st_next;
  logic                      rsp_valid_next;
  pet_pkg::rsp_t             rsp_next;

  logic accept;
  logic can_load;
  logic load;
  logic last_slot;
  logic empty;
  logic full;
  logic stall;

  assign accept    = cmd_valid && cmd_ready;
  assign can_load  = !rsp_valid || rsp_ready;
  assign last_slot = (CNT_W'(idx) + 1'b1) >= count;
  assign empty     = count == '0;
  assign full      = count == CNT_W'(MAX_EVENTS);
  assign stall     = (op == pet_pkg::OP_PROCESS) && ures.fire && !can_load;
  assign cmd_ready = state == pet_pkg::S_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pet_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd.func)
            pet_pkg::OP_TICK: begin
              state_next = (cmd.count_enable && !empty) ? pet_pkg::S_READ : pet_pkg::S_DONE;
            end
            pet_pkg::OP_PROCESS, pet_pkg::OP_REMOVE, pet_pkg::OP_PAUSE,
            pet_pkg::OP_RESUME: begin
              state_next = empty ? pet_pkg::S_DONE : pet_pkg::S_READ;
            end
            default: begin
              state_next = pet_pkg::S_DONE;
            end
          endcase
        end
      end
      pet_pkg::S_READ: begin
        state_next = pet_pkg::S_EXEC;
      end
      pet_pkg::S_EXEC: begin
        if (!stall) begin
          if (op == pet_pkg::OP_REMOVE && ures.match && !last_slot) begin
            state_next = pet_pkg::S_MOVE_RD;
          end else if (last_slot || (op == pet_pkg::OP_REMOVE && ures.match)) begin
            state_next = pet_pkg::S_DONE;
          end else begin
            state_next = pet_pkg::S_READ;
          end
        end
      end
      pet_pkg::S_MOVE_RD: begin
        state_next = pet_pkg::S_MOVE;
      end
      pet_pkg::S_MOVE: begin
        state_next = last_slot ? pet_pkg::S_DONE : pet_pkg::S_MOVE_RD;
      end
      pet_pkg::S_DONE: begin
        if (can_load) begin
          state_next = pet_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pet_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_next       = op;
    tag_next      = tag;
    per_next      = per;
    en_next       = en;
    count_next    = count;
    idx_next      = idx;
    res_slot_next = res_slot;
    found_next    = found;
    st_next       = st;
    we            = 1'b0;
    wa            = idx;
    wd            = ures.upd;
    load          = 1'b0;
    rsp_next      = rsp;
    case (state)
      pet_pkg::S_IDLE: begin
        if (accept) begin
          op_next       = cmd.func;
          tag_next      = cmd.event_tag;
          per_next      = cmd.period;
          en_next       = cmd.count_enable;
          idx_next      = '0;
          res_slot_next = '0;
          found_next    = 1'b0;
          st_next       = pet_pkg::ST_OK;
          case (cmd.func)
            pet_pkg::OP_ADD: begin
              if (full) begin
                st_next = pet_pkg::ST_FULL;
              end else begin
                we            = 1'b1;
                wa            = IDX_W'(count);
                wd.tag        = cmd.event_tag;
                wd.period     = cmd.period;
                wd.counter    = '0;
                wd.active     = 1'b1;
                res_slot_next = IDX_W'(count);
                count_next    = count + 1'b1;
              end
            end
            pet_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            pet_pkg::OP_REMOVE, pet_pkg::OP_PAUSE, pet_pkg::OP_RESUME: begin
              if (empty) begin
                st_next = pet_pkg::ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pet_pkg::S_EXEC: begin
        if (!stall) begin
          we = ures.hit && (op != pet_pkg::OP_REMOVE);
          if (op == pet_pkg::OP_PROCESS && ures.fire) begin
            load               = 1'b1;
            rsp_next.fired     = 1'b1;
            rsp_next.fired_tag = rd.tag;
            rsp_next.slot      = pet_pkg::SLOT_W'(idx);
            rsp_next.status    = pet_pkg::ST_OK;
            rsp_next.last      = 1'b0;
          end
          if (op == pet_pkg::OP_REMOVE && ures.match) begin
            res_slot_next = idx;
            if (last_slot) begin
              count_next = count - 1'b1;
            end else begin
              idx_next = idx + 1'b1;
            end
          end else begin
            if (last_slot) begin
              if (op == pet_pkg::OP_REMOVE) begin
                st_next = pet_pkg::ST_NOT_FOUND;
              end else if (op == pet_pkg::OP_PAUSE || op == pet_pkg::OP_RESUME) begin
                st_next = (found || ures.match) ? pet_pkg::ST_OK : pet_pkg::ST_NOT_FOUND;
              end
            end else begin
              idx_next = idx + 1'b1;
            end
            found_next = found || ures.match;
          end
        end
      end
      pet_pkg::S_MOVE: begin
        we = 1'b1;
        wa = idx - 1'b1;
        wd = rd;
        if (last_slot) begin
          count_next = count - 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      pet_pkg::S_DONE: begin
        if (can_load) begin
          load           = 1'b1;
          rsp_next.fired = 1'b0;
          if (op == pet_pkg::OP_TICK || op == pet_pkg::OP_PROCESS ||
              op == pet_pkg::OP_CLEAR) begin
            rsp_next.fired_tag = '0;
          end else begin
            rsp_next.fired_tag = tag;
          end
          rsp_next.slot   = pet_pkg::SLOT_W'(res_slot);
          rsp_next.status = st;
          rsp_next.last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp_valid_next = load || (rsp_valid && !rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pet_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    op       <= op_next;
    tag      <= tag_next;
    per      <= per_next;
    en       <= en_next;
    idx      <= idx_next;
    res_slot <= res_slot_next;
    found    <= found_next;
    st       <= st_next;
    rsp      <= rsp_next;
  end

  `PET_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_EVENTS))
  `PET_ASSERT_IMPLY(a_walk_in_fill, clk, rst,
    state == pet_pkg::S_EXEC || state == pet_pkg::S_MOVE, CNT_W'(idx) < count)
  `PET_ASSERT_IMPLY(a_fired_not_last, clk, rst, rsp_valid && rsp.fired, !rsp.last)
  `PET_ASSERT_NEXT(a_remove_shrinks, clk, rst,
    state == pet_pkg::S_MOVE && last_slot, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

/* hw/rtl/periodic_event_timer_table_unit.sv */
// Periodic event timer table: a table of up to MAX_EVENTS tagged periodic events,
// walked one slot at a time by a sequencer through a shared compare and update
// unit over an entry RAM with one write port and one registered read port. Add,
// remove all and unused codes go straight from idle to the closing beat, as do tick
// without count_enable and any walking operation on an empty table. Tick (with
// count_enable), process, pause, resume and remove pass each occupied slot, up to
// the matching slot for remove, through a read state and an execute state, then
// go to the closing beat; remove first reads and rewrites each later entry one
// slot down. The slot rate is set by the RAM's registered read port. Process
// emits one beat per fired entry and holds its walk while a result beat waits on
// rsp_ready. The command channel is ready only between commands. The entry RAM
// needs no clearing after reset; only slots below the fill count are ever read.
// Depends on pet_pkg, pet_entry_ram, pet_slot_unit and pet_ctrl.
`default_nettype none

module periodic_event_timer_table_unit #(
  parameter int MAX_EVENTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire pet_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pet_pkg::rsp_t      rsp
);

  localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  logic [2:0]                op;
  logic [pet_pkg::TAG_W-1:0] tag;
  logic [IDX_W-1:0]          idx;
  logic                      we;
  logic [IDX_W-1:0]          wa;
  pet_pkg::entry_t           wd;
  pet_pkg::entry_t           rd;
  pet_pkg::unit_res_t        ures;

  pet_entry_ram #(
    .DEPTH (MAX_EVENTS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (idx),
    .rd  (rd)
  );

  pet_slot_unit u_unit (
    .op    (op),
    .tag   (tag),
    .entry (rd),
    .res   (ures)
  );

  pet_ctrl #(
    .MAX_EVENTS (MAX_EVENTS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .op        (op),
    .tag       (tag),
    .idx       (idx),
    .we        (we),
    .wa        (wa),
    .wd        (wd),
    .rd        (rd),
    .ures      (ures)
  );

endmodule

`default_nettype wire
